FILE: src/rqes_pkg.sv
// Shared types and constants for the RGB quantizer with error statistics.
package rqes_pkg;

  localparam int NUM_CH   = 3;
  localparam int PIX_W    = 8;
  localparam int BITS_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int ERRSQ_W  = 15;  // |v - q| never exceeds 128
  localparam int ENSQ_W   = 16;
  localparam int ERR_OUT_W = 39;
  localparam int EN_OUT_W  = 40;
  localparam int CNT_OUT_W = 25;

  // Per-channel index into the packed lane arrays
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_BITS   = 2'd0,
    CFG_GREEN_BITS = 2'd1,
    CFG_BLUE_BITS  = 2'd2
  } cfg_idx_t;

  // One classified pixel as it travels from the front end to the back end
  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0]   quant;
    logic [NUM_CH-1:0][ERRSQ_W-1:0] err_sq;
    logic [NUM_CH-1:0][ENSQ_W-1:0]  en_sq;
    logic                           last;
  } pix_item_t;

endpackage

FILE: src/rqes_front.sv
// Front end: configuration registers, per-channel quantizer and square terms.
module rqes_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rqes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rqes_pkg::BITS_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rqes_pkg::PIX_W-1:0]          in_red_in,
  input  logic [rqes_pkg::PIX_W-1:0]          in_green_in,
  input  logic [rqes_pkg::PIX_W-1:0]          in_blue_in,
  input  logic                                in_last_pixel,
  input  logic                                q_full,
  output logic                                q_push,
  output rqes_pkg::pix_item_t                 q_item
);

  logic [rqes_pkg::NUM_CH-1:0][rqes_pkg::BITS_W-1:0] bits_r;
  logic [rqes_pkg::NUM_CH-1:0][rqes_pkg::BITS_W-1:0] bits_nxt;
  logic [rqes_pkg::NUM_CH-1:0][rqes_pkg::PIX_W-1:0]  pix;

  // Midpoint of the value's interval; eight or more bits is identity
  function automatic logic [rqes_pkg::PIX_W-1:0] quantize(
    input logic [rqes_pkg::PIX_W-1:0]  v,
    input logic [rqes_pkg::BITS_W-1:0] b
  );
    logic [rqes_pkg::PIX_W:0]   w;
    logic [rqes_pkg::PIX_W-1:0] low_mask;
    logic [rqes_pkg::PIX_W-1:0] half;
    w        = (rqes_pkg::PIX_W+1)'(256) >> b[2:0];
    low_mask = rqes_pkg::PIX_W'(w - (rqes_pkg::PIX_W+1)'(1));
    half     = rqes_pkg::PIX_W'(w >> 1);
    if (b >= rqes_pkg::BITS_W'(8)) begin
      quantize = v;
    end else begin
      quantize = (v & ~low_mask) + half;
    end
  endfunction

  // Register write decode
  always_comb begin
    bits_nxt = bits_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rqes_pkg::CFG_RED_BITS:   bits_nxt[rqes_pkg::CH_RED]   = cfg_wdata;
        rqes_pkg::CFG_GREEN_BITS: bits_nxt[rqes_pkg::CH_GREEN] = cfg_wdata;
        rqes_pkg::CFG_BLUE_BITS:  bits_nxt[rqes_pkg::CH_BLUE]  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= {rqes_pkg::NUM_CH{rqes_pkg::BITS_W'(8)}};
    end else begin
      bits_r <= bits_nxt;
    end
  end

  assign pix[rqes_pkg::CH_RED]   = in_red_in;
  assign pix[rqes_pkg::CH_GREEN] = in_green_in;
  assign pix[rqes_pkg::CH_BLUE]  = in_blue_in;

  // Quantize and square each lane
  always_comb begin
    logic [rqes_pkg::PIX_W-1:0] q;
    logic [rqes_pkg::PIX_W-1:0] d;
    q_item.last = in_last_pixel;
    for (int c = 0; c < rqes_pkg::NUM_CH; c++) begin
      q = quantize(pix[c], bits_r[c]);
      d = (pix[c] >= q) ? (pix[c] - q) : (q - pix[c]);
      q_item.quant[c]  = q;
      q_item.err_sq[c] = rqes_pkg::ERRSQ_W'(d * d);
      q_item.en_sq[c]  = rqes_pkg::ENSQ_W'(pix[c]) * rqes_pkg::ENSQ_W'(pix[c]);
    end
  end

  // Transaction goes straight into the queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

FILE: src/rqes_fifo.sv
// Short queue between the front and back ends.
module rqes_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rqes_pkg::pix_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output rqes_pkg::pix_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rqes_pkg::pix_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/rqes_back.sv
// Back end: saturating frame accumulators and the result register.
module rqes_back #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_empty,
  input  rqes_pkg::pix_item_t                           q_item,
  output logic                                          q_pop,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [rqes_pkg::PIX_W-1:0]                    out_red_out,
  output logic [rqes_pkg::PIX_W-1:0]                    out_green_out,
  output logic [rqes_pkg::PIX_W-1:0]                    out_blue_out,
  output logic                                          out_frame_done,
  output logic [rqes_pkg::ERR_OUT_W-1:0]                out_error_red,
  output logic [rqes_pkg::ERR_OUT_W-1:0]                out_error_green,
  output logic [rqes_pkg::ERR_OUT_W-1:0]                out_error_blue,
  output logic [rqes_pkg::EN_OUT_W-1:0]                 out_energy_red,
  output logic [rqes_pkg::EN_OUT_W-1:0]                 out_energy_green,
  output logic [rqes_pkg::EN_OUT_W-1:0]                 out_energy_blue,
  output logic [rqes_pkg::CNT_OUT_W-1:0]                out_pixel_total
);

  // Accumulator widths follow from the saturation limits
  localparam int ERR_W = MAX_PIXELS_LOG2 + 15;
  localparam int EN_W  = MAX_PIXELS_LOG2 + 16;
  localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
  localparam logic [ERR_W-1:0] ERR_LIMIT = ERR_W'(16384) << MAX_PIXELS_LOG2;
  localparam logic [EN_W-1:0]  EN_LIMIT  = EN_W'(65025) << MAX_PIXELS_LOG2;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;

  localparam int NCH = rqes_pkg::NUM_CH;

  logic [NCH-1:0][ERR_W-1:0] err_acc_r, err_acc_nxt, err_sum;
  logic [NCH-1:0][EN_W-1:0]  en_acc_r, en_acc_nxt, en_sum;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt, cnt_sum;
  logic                      out_valid_r;

  logic [NCH-1:0][rqes_pkg::PIX_W-1:0]     quant_r;
  logic                                    done_r;
  logic [NCH-1:0][rqes_pkg::ERR_OUT_W-1:0] err_out_r;
  logic [NCH-1:0][rqes_pkg::EN_OUT_W-1:0]  en_out_r;
  logic [rqes_pkg::CNT_OUT_W-1:0]          cnt_out_r;

  // Take from the queue whenever the result register is free or draining
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // Saturating sums including the current pixel
  always_comb begin
    logic [ERR_W:0]  es;
    logic [EN_W:0]   ns;
    logic [CNT_W:0]  cs;
    for (int c = 0; c < NCH; c++) begin
      es = {1'b0, err_acc_r[c]} + (ERR_W+1)'(q_item.err_sq[c]);
      ns = {1'b0, en_acc_r[c]} + (EN_W+1)'(q_item.en_sq[c]);
      err_sum[c] = (es > {1'b0, ERR_LIMIT}) ? ERR_LIMIT : es[ERR_W-1:0];
      en_sum[c]  = (ns > {1'b0, EN_LIMIT}) ? EN_LIMIT : ns[EN_W-1:0];
    end
    cs = {1'b0, cnt_r} + (CNT_W+1)'(1);
    cnt_sum = (cs > {1'b0, CNT_LIMIT}) ? CNT_LIMIT : cs[CNT_W-1:0];
  end

  // Accumulators clear after the last pixel of a frame
  always_comb begin
    err_acc_nxt = err_acc_r;
    en_acc_nxt  = en_acc_r;
    cnt_nxt     = cnt_r;
    if (q_pop) begin
      if (q_item.last) begin
        err_acc_nxt = '0;
        en_acc_nxt  = '0;
        cnt_nxt     = '0;
      end else begin
        err_acc_nxt = err_sum;
        en_acc_nxt  = en_sum;
        cnt_nxt     = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_acc_r   <= '0;
      en_acc_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      err_acc_r <= err_acc_nxt;
      en_acc_r  <= en_acc_nxt;
      cnt_r     <= cnt_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; statistics are zero except on the last pixel
  always_ff @(posedge clk) begin
    if (q_pop) begin
      quant_r <= q_item.quant;
      done_r  <= q_item.last;
      for (int c = 0; c < NCH; c++) begin
        err_out_r[c] <= q_item.last ? rqes_pkg::ERR_OUT_W'(err_sum[c]) : '0;
        en_out_r[c]  <= q_item.last ? rqes_pkg::EN_OUT_W'(en_sum[c]) : '0;
      end
      cnt_out_r <= q_item.last ? rqes_pkg::CNT_OUT_W'(cnt_sum) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red_out      = quant_r[rqes_pkg::CH_RED];
  assign out_green_out    = quant_r[rqes_pkg::CH_GREEN];
  assign out_blue_out     = quant_r[rqes_pkg::CH_BLUE];
  assign out_frame_done   = done_r;
  assign out_error_red    = err_out_r[rqes_pkg::CH_RED];
  assign out_error_green  = err_out_r[rqes_pkg::CH_GREEN];
  assign out_error_blue   = err_out_r[rqes_pkg::CH_BLUE];
  assign out_energy_red   = en_out_r[rqes_pkg::CH_RED];
  assign out_energy_green = en_out_r[rqes_pkg::CH_GREEN];
  assign out_energy_blue  = en_out_r[rqes_pkg::CH_BLUE];
  assign out_pixel_total  = cnt_out_r;

endmodule

FILE: src/rgb_uniform_quantizer_error_stats.sv
// Top level of the RGB uniform quantizer with per-frame error statistics.
//
//   Port group  Direction  Handshake          Transaction
//   in_*        input      in_valid/in_stall  one RGB pixel plus frame-end flag
//   out_*       output     out_valid/out_stall  quantized pixel plus frame sums
//   cfg_*       input      cfg_we             bit count for one channel
//
// One pixel per clock sustained while out_stall is low; an accepted pixel passes
// through the queue, then the result register, before it is presented on out_*.
// The four-entry queue absorbs output stalls; in_stall rises only when it is full.
// Reset (synchronous, rst_n low) sets all bit counts to 8, clears sums and queue.
module rgb_uniform_quantizer_error_stats #(
  parameter int MAX_PIXELS_LOG2 = 24,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rqes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rqes_pkg::BITS_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rqes_pkg::PIX_W-1:0]        in_red_in,
  input  logic [rqes_pkg::PIX_W-1:0]        in_green_in,
  input  logic [rqes_pkg::PIX_W-1:0]        in_blue_in,
  input  logic                              in_last_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rqes_pkg::PIX_W-1:0]        out_red_out,
  output logic [rqes_pkg::PIX_W-1:0]        out_green_out,
  output logic [rqes_pkg::PIX_W-1:0]        out_blue_out,
  output logic                              out_frame_done,
  output logic [rqes_pkg::ERR_OUT_W-1:0]    out_error_red,
  output logic [rqes_pkg::ERR_OUT_W-1:0]    out_error_green,
  output logic [rqes_pkg::ERR_OUT_W-1:0]    out_error_blue,
  output logic [rqes_pkg::EN_OUT_W-1:0]     out_energy_red,
  output logic [rqes_pkg::EN_OUT_W-1:0]     out_energy_green,
  output logic [rqes_pkg::EN_OUT_W-1:0]     out_energy_blue,
  output logic [rqes_pkg::CNT_OUT_W-1:0]    out_pixel_total
);

  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  rqes_pkg::pix_item_t push_item;
  rqes_pkg::pix_item_t pop_item;

  // Classify and quantize
  rqes_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_last_pixel (in_last_pixel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // Decoupling queue
  rqes_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  // Accumulate and report
  rqes_back #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_frame_done   (out_frame_done),
    .out_error_red    (out_error_red),
    .out_error_green  (out_error_green),
    .out_error_blue   (out_error_blue),
    .out_energy_red   (out_energy_red),
    .out_energy_green (out_energy_green),
    .out_energy_blue  (out_energy_blue),
    .out_pixel_total  (out_pixel_total)
  );

endmodule
